// ===== rtl/spdsc_pkg.sv =====
// shared types and constants of the sync packet deframer with additive checksum
// depends on nothing; imported by every module of the block
package spdsc_pkg;

    // framing constants
    localparam logic [7:0]  SYNC_FIRST    = 8'hEE;
    localparam logic [7:0]  SYNC_SECOND   = 8'hBB;
    localparam logic [15:0] MIN_LENGTH    = 16'd6;
    localparam logic [15:0] MAX_LEN_RESET = 16'd40000;
    localparam logic [3:0]  TYPE_NIB_LOW  = 4'd2;
    localparam logic [3:0]  TYPE_NIB_HIGH = 4'd8;
    localparam logic [2:0]  MODE_NONE     = 3'd7;
    localparam int          MODE_COUNT_DEF = 7;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;
    localparam logic [1:0] KIND_SEGMENT = 2'd3;

    // widths of the stream words
    localparam int RES_BITS   = 154;
    localparam int TDATA_BITS = 160;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [2:0]  mode;
        logic [5:0]  fee;
        logic [15:0] packet_length;
        logic [3:0]  trigger_status;
        logic [11:0] trig_number;
        logic [15:0] stored_sum;
        logic [23:0] computed_sum;
        logic        sum_ok;
        logic [31:0] error_count;
        logic [31:0] packet_count;
    } res_t;

    // request from the parser to the per-mode counters
    typedef struct packed {
        logic [2:0] mode;
        logic       inc_pkt;
        logic       inc_err;
    } cnt_req_t;

    // counter values seen by the parser
    typedef struct packed {
        logic [31:0] pkt_count;
        logic [31:0] err_count;
    } cnt_rsp_t;

    // saturating increment of a 32-bit count
    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/spdsc_counters.sv =====
// per-mode saturating packet and error counters
// depends on spdsc_pkg
module spdsc_counters #(
    parameter int MODE_COUNT = spdsc_pkg::MODE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spdsc_pkg::cnt_req_t req,
    output spdsc_pkg::cnt_rsp_t rsp
);
    import spdsc_pkg::*;

    localparam int IDX_W = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;

    logic [31:0] pkt_reg [MODE_COUNT];
    logic [31:0] err_reg [MODE_COUNT];
    logic [IDX_W-1:0] idx;
    logic [31:0] pkt_sel;
    logic [31:0] err_sel;
    logic [31:0] pkt_inc_val;
    logic [31:0] err_inc_val;

    // one shared read address for both arrays
    assign idx         = req.mode[IDX_W-1:0];
    assign pkt_sel     = pkt_reg[idx];
    assign err_sel     = err_reg[idx];
    assign pkt_inc_val = sat_inc32(pkt_sel);
    assign err_inc_val = sat_inc32(err_sel);

    // error count already includes a failure of this packet
    assign rsp.pkt_count = pkt_sel;
    assign rsp.err_count = req.inc_err ? err_inc_val : err_sel;

    // counter update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODE_COUNT; i++)
            begin
                pkt_reg[i] <= '0;
                err_reg[i] <= '0;
            end
        end
        else
        begin
            if (req.inc_pkt)
            begin
                pkt_reg[idx] <= pkt_inc_val;
            end
            if (req.inc_err)
            begin
                err_reg[idx] <= err_inc_val;
            end
        end
    end

endmodule

// ===== rtl/spdsc_parser.sv =====
// framing state machine: sync hunt, header fields, running sum, verdict build
// depends on spdsc_pkg; uses the counter values from spdsc_counters
module spdsc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic [15:0]         max_length,
    input  spdsc_pkg::cnt_rsp_t cnt_rsp,
    output spdsc_pkg::cnt_req_t cnt_req,
    output logic                res_valid,
    output spdsc_pkg::res_t     res
);
    import spdsc_pkg::*;

    // phase codes
    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_TYPE  = 4'd2;
    localparam logic [3:0] PH_FEE   = 4'd3;
    localparam logic [3:0] PH_LENH  = 4'd4;
    localparam logic [3:0] PH_LENL  = 4'd5;
    localparam logic [3:0] PH_BODY  = 4'd6;
    localparam logic [3:0] PH_SUMH  = 4'd7;
    localparam logic [3:0] PH_SUML  = 4'd8;

    logic [3:0]  phase_reg,  phase_next;
    logic [15:0] pos_reg,    pos_next;
    logic [15:0] len_reg,    len_next;
    logic [23:0] sum_reg,    sum_next;
    logic [2:0]  mode_reg,   mode_next;
    logic [5:0]  fee_reg,    fee_next;
    logic [7:0]  trig_hi_reg, trig_hi_next;
    logic [7:0]  trig_lo_reg, trig_lo_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;

    logic [3:0]  nib;
    logic        type_known;
    logic [2:0]  new_mode;
    logic [2:0]  cur_mode;
    logic [24:0] sum_wide;
    logic [23:0] sum_sat;
    logic [15:0] len_full;
    logic [16:0] pos_plus2;
    logic [15:0] stored;
    logic        sum_match;

    // shared datapath pieces
    assign nib        = in_byte[7:4];
    assign type_known = (nib >= TYPE_NIB_LOW) && (nib <= TYPE_NIB_HIGH);
    assign new_mode   = 3'(nib - TYPE_NIB_LOW);
    assign cur_mode   = (mode_reg == MODE_NONE) ? 3'd0 : mode_reg;
    assign sum_wide   = {1'b0, sum_reg} + {17'd0, in_byte};
    assign sum_sat    = sum_wide[24] ? 24'hFF_FFFF : sum_wide[23:0];
    assign len_full   = {len_reg[15:8], in_byte};
    assign pos_plus2  = {1'b0, pos_reg} + 17'd2;
    assign stored     = {sum_hi_reg, in_byte};
    assign sum_match  = (sum_reg == {8'd0, stored});

    // counter requests
    always_comb
    begin
        cnt_req.mode    = (phase_reg == PH_TYPE) ? new_mode : cur_mode;
        cnt_req.inc_pkt = fire && (phase_reg == PH_TYPE) && type_known;
        cnt_req.inc_err = fire && (phase_reg == PH_SUML) && !sum_match;
    end

    // next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        mode_next    = mode_reg;
        fee_next     = fee_reg;
        trig_hi_next = trig_hi_reg;
        trig_lo_next = trig_lo_reg;
        sum_hi_next  = sum_hi_reg;
        res_valid    = 1'b0;
        res          = '0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                phase_next = (in_byte == SYNC_SECOND) ? PH_TYPE : PH_HUNT;
            end
            PH_TYPE:
            begin
                if (!type_known)
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res.kind   = KIND_UNKNOWN;
                end
                else
                begin
                    if (new_mode != mode_reg)
                    begin
                        mode_next = new_mode;
                        res_valid = 1'b1;
                        res.kind  = KIND_SEGMENT;
                        res.mode  = new_mode;
                    end
                    sum_next   = {16'd0, in_byte};
                    phase_next = PH_FEE;
                end
            end
            PH_FEE:
            begin
                fee_next   = in_byte[5:0];
                sum_next   = sum_sat;
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                len_next   = {in_byte, 8'd0};
                sum_next   = sum_sat;
                phase_next = PH_LENL;
            end
            PH_LENL:
            begin
                len_next = len_full;
                sum_next = sum_sat;
                if ((len_full < MIN_LENGTH) || (len_full > max_length))
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    pos_next   = 16'd4;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                sum_next = sum_sat;
                if (pos_plus2 < {1'b0, len_reg})
                begin
                    pos_next          = pos_plus2[15:0] - 16'd1;
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.payload_byte  = in_byte;
                    res.mode          = cur_mode;
                    res.fee           = fee_reg;
                    res.packet_length = len_reg;
                end
                else if (pos_plus2 == {1'b0, len_reg})
                begin
                    trig_hi_next = in_byte;
                    pos_next     = pos_plus2[15:0] - 16'd1;
                end
                else
                begin
                    trig_lo_next = in_byte;
                    phase_next   = PH_SUMH;
                end
            end
            PH_SUMH:
            begin
                sum_hi_next = in_byte;
                phase_next  = PH_SUML;
            end
            PH_SUML:
            begin
                res_valid          = 1'b1;
                res.kind           = KIND_VERDICT;
                res.mode           = cur_mode;
                res.fee            = fee_reg;
                res.packet_length  = len_reg;
                res.trigger_status = trig_hi_reg[7:4];
                res.trig_number    = {trig_hi_reg[3:0], trig_lo_reg};
                res.stored_sum     = stored;
                res.computed_sum   = sum_reg;
                res.sum_ok         = sum_match;
                res.error_count    = cnt_rsp.err_count;
                res.packet_count   = cnt_rsp.pkt_count;
                phase_next         = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // framing state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            pos_reg     <= '0;
            len_reg     <= '0;
            sum_reg     <= '0;
            mode_reg    <= MODE_NONE;
            fee_reg     <= '0;
            trig_hi_reg <= '0;
            trig_lo_reg <= '0;
            sum_hi_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            mode_reg    <= mode_next;
            fee_reg     <= fee_next;
            trig_hi_reg <= trig_hi_next;
            trig_lo_reg <= trig_lo_next;
            sum_hi_reg  <= sum_hi_next;
        end
    end

    // a verdict always returns to the hunt
    a_verdict_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_SUML) |=> (phase_reg == PH_HUNT))
        else $error("verdict did not return to hunt");

    // the body never runs past the length field
    a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (pos_reg < len_reg))
        else $error("body position beyond length");

    // a mode is set whenever a packet body is read
    a_body_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY || phase_reg == PH_SUML) |-> (mode_reg != MODE_NONE))
        else $error("packet without mode");

endmodule

// ===== rtl/spdsc_out_buf.sv =====
// result register with one skid entry, so input keeps flowing during a stall until the skid entry fills
// depends on spdsc_pkg
module spdsc_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spdsc_pkg::res_t push_data,
    output logic            push_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output spdsc_pkg::res_t out_data
);
    import spdsc_pkg::*;

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    // buffer steering
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // skid entry only holds data behind a full result register
    a_skid_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid full with empty result register");

    // no request is pushed into a full skid
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push into full buffer");

    // a drained skid refills the result register
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> main_valid_reg)
        else $error("skid drain lost a result");

endmodule

// ===== rtl/sync_packet_deframer_sum_check_unit.sv =====
// top level of the sync packet deframer with additive checksum
// depends on spdsc_pkg, spdsc_parser, spdsc_counters, spdsc_out_buf
//
//  channel  | direction | request moves
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | one raw stream byte
//  m_axis   | out       | one event: payload byte, verdict, unknown type, segment
//  cfg      | in        | new max_length value
//
// every byte is handled in the cycle it is accepted; one byte per cycle sustained while the skid entry is not full
// while a result waits, bytes keep flowing until one more result fills the skid entry
// s_tready drops only while the skid entry is full
// reset clears framing state, mode to none, all counters, max_length to 40000
module sync_packet_deframer_sum_check_unit #(
    parameter int MODE_COUNT = spdsc_pkg::MODE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // in_byte [7:0]
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // payload_byte [7:0], mode [10:8], fee [16:11], packet_length [32:17],
    // trigger_status [36:33], trig_number [48:37], stored_sum [64:49],
    // computed_sum [88:65], sum_ok [89], error_count [121:90],
    // packet_count [153:122], zero fill [159:154]
    output logic [spdsc_pkg::TDATA_BITS-1:0] m_tdata,
    // kind [1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // max_length [15:0]
    input  logic [15:0] cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);
    import spdsc_pkg::*;

    logic        fire;
    logic [15:0] max_len_reg;
    cnt_req_t    cnt_req;
    cnt_rsp_t    cnt_rsp;
    logic        res_valid;
    res_t        res;
    res_t        out_res;
    logic        push_ready;

    assign s_tready  = push_ready;
    assign fire      = s_tvalid && push_ready;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            max_len_reg <= cfg_data;
        end
    end

    spdsc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .in_byte    (s_tdata),
        .max_length (max_len_reg),
        .cnt_rsp    (cnt_rsp),
        .cnt_req    (cnt_req),
        .res_valid  (res_valid),
        .res        (res)
    );

    spdsc_counters #(
        .MODE_COUNT (MODE_COUNT)
    ) u_counters (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .rsp   (cnt_rsp)
    );

    spdsc_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire && res_valid),
        .push_data  (res),
        .push_ready (push_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    // stream packing, first field lowest
    assign m_tuser = out_res.kind;
    assign m_tdata = {
        (TDATA_BITS - RES_BITS)'(0),
        out_res.packet_count,
        out_res.error_count,
        out_res.sum_ok,
        out_res.computed_sum,
        out_res.stored_sum,
        out_res.trig_number,
        out_res.trigger_status,
        out_res.packet_length,
        out_res.fee,
        out_res.mode,
        out_res.payload_byte
    };

endmodule
